/* rtl/add_sub_paren_expression_evaluator_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the add/subtract expression evaluator
// Concurrent checks that are compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ADD_SUB_PAREN_EXPRESSION_EVALUATOR_MACROS_SVH
`define ADD_SUB_PAREN_EXPRESSION_EVALUATOR_MACROS_SVH
`ifndef SYNTHESIS
`define ASPE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define ASPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASPE_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASPE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/aspe_pkg.sv */
// ----------------------------------------------------------------------------
// Expression evaluator package
// Character codes, the token passed from the front to the back, and the
// layout of one parenthesis stack entry.
// ----------------------------------------------------------------------------
package aspe_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned CHAR_W = 8;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_OPEN  = 8'h28;
   localparam logic [CHAR_W-1:0] CHAR_CLOSE = 8'h29;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      KIND_COMMIT,
      KIND_OPEN,
      KIND_CLOSE
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [DATA_W-1:0] num;
      logic              neg;
      logic              last;
   } token_type;

   typedef struct packed {
      logic [DATA_W-1:0] sum;
      logic              neg;
   } entry_type;

endpackage

/* rtl/aspe_front.sv */
// ----------------------------------------------------------------------------
// Expression evaluator front end
// Accepts characters, builds decimal numbers, tracks the sign and issues one
// token for every character that changes the running sum or the stack.
// ----------------------------------------------------------------------------
module aspe_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [aspe_pkg::CHAR_W-1:0]       req_char_code,
   input  logic                              req_last,
   input  logic                              q_full,
   output logic                              q_push,
   output aspe_pkg::token_type               q_token
);

   logic                            accept;
   logic                            is_digit;
   logic [aspe_pkg::CHAR_W-1:0]     digit;
   logic [aspe_pkg::DATA_W-1:0]     num_next;
   logic [aspe_pkg::DATA_W-1:0]     num_ff;
   logic [aspe_pkg::DATA_W-1:0]     num_in;
   logic                            neg_ff;
   logic                            neg_in;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign is_digit  = req_char_code >= aspe_pkg::CHAR_ZERO;
   assign digit     = req_char_code - aspe_pkg::CHAR_ZERO;
   assign num_next  = {num_ff[aspe_pkg::DATA_W-4:0], 3'b000}
                    + {num_ff[aspe_pkg::DATA_W-2:0], 1'b0}
                    + aspe_pkg::DATA_W'(digit);

   always_comb begin
      num_in        = num_ff;
      neg_in        = neg_ff;
      q_push        = 1'b0;
      q_token.kind  = aspe_pkg::KIND_COMMIT;
      q_token.num   = num_ff;
      q_token.neg   = neg_ff;
      q_token.last  = req_last;
      if (accept) begin
         if (is_digit) begin
            num_in = num_next;
            if (req_last) begin
               q_push      = 1'b1;
               q_token.num = num_next;
            end
         end else begin
            q_push = 1'b1;
            num_in = '0;
            priority if (req_char_code == aspe_pkg::CHAR_PLUS) begin
               neg_in = 1'b0;
            end else if (req_char_code == aspe_pkg::CHAR_MINUS) begin
               neg_in = 1'b1;
            end else if (req_char_code == aspe_pkg::CHAR_OPEN) begin
               neg_in       = 1'b0;
               q_token.kind = aspe_pkg::KIND_OPEN;
            end else if (req_char_code == aspe_pkg::CHAR_CLOSE) begin
               q_token.kind = aspe_pkg::KIND_CLOSE;
            end else begin
               neg_in = neg_ff;
            end
         end
         if (req_last) begin
            num_in = '0;
            neg_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= '0;
         neg_ff <= 1'b0;
      end else begin
         num_ff <= num_in;
         neg_ff <= neg_in;
      end
   end

endmodule

/* rtl/aspe_queue.sv */
// ----------------------------------------------------------------------------
// Expression evaluator token queue
// A two-entry queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
`include "add_sub_paren_expression_evaluator_macros.svh"

module aspe_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  aspe_pkg::token_type   push_token,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output aspe_pkg::token_type   head
);

   aspe_pkg::token_type entries_ff [aspe_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full      = count_ff == 2'(aspe_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_token;
      end
   end

   `ASPE_ASSERT_IMPLIES(a_q_bound, clock, reset, 1'b1, count_ff <= 2'(aspe_pkg::QUEUE_DEPTH))
   `ASPE_ASSERT_IMPLIES(a_q_pop_nonempty, clock, reset, pop, count_ff != '0)

endmodule

/* rtl/aspe_back.sv */
// ----------------------------------------------------------------------------
// Expression evaluator back end
// Executes tokens against the running sum and the parenthesis stack and
// registers the result of each expression.
// ----------------------------------------------------------------------------
`include "add_sub_paren_expression_evaluator_macros.svh"

module aspe_back #(
   parameter int unsigned STACK_DEPTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                tok_valid,
   input  aspe_pkg::token_type                 tok,
   output logic                                tok_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [aspe_pkg::DATA_W-1:0]  rsp_value,
   output logic                                rsp_error
);

   localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   aspe_pkg::entry_type stack_mem [STACK_DEPTH];

   logic                          go;
   logic [aspe_pkg::DATA_W-1:0]   sum_ff;
   logic [aspe_pkg::DATA_W-1:0]   sum_in;
   logic [aspe_pkg::DATA_W-1:0]   sum_commit;
   logic [aspe_pkg::DATA_W-1:0]   sum_close;
   logic [aspe_pkg::DATA_W-1:0]   result_sum;
   logic [SPW-1:0]                sp_ff;
   logic [SPW-1:0]                sp_in;
   logic [SPW-1:0]                rd_full;
   logic                          err_ff;
   logic                          err_in;
   logic                          result_err;
   aspe_pkg::entry_type           tos_ff;
   aspe_pkg::entry_type           tos_in;
   aspe_pkg::entry_type           below_ff;
   aspe_pkg::entry_type           wr_data;
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic [AW-1:0]                 rd_addr;
   logic                          rsp_valid_ff;
   logic [aspe_pkg::DATA_W-1:0]   rsp_value_ff;
   logic                          rsp_error_ff;

   assign go      = tok_valid && (!tok.last || !rsp_valid_ff || !rsp_stall);
   assign tok_pop = go;

   assign sum_commit = sum_ff + (tok.num ^ {aspe_pkg::DATA_W{tok.neg}})
                     + aspe_pkg::DATA_W'(tok.neg);
   assign sum_close  = tos_ff.sum + (sum_commit ^ {aspe_pkg::DATA_W{tos_ff.neg}})
                     + aspe_pkg::DATA_W'(tos_ff.neg);

   assign wr_addr      = sp_ff[AW-1:0];
   assign wr_data.sum  = sum_commit;
   assign wr_data.neg  = tok.neg;

   always_comb begin
      sum_in     = sum_ff;
      sp_in      = sp_ff;
      err_in     = err_ff;
      tos_in     = tos_ff;
      wr_en      = 1'b0;
      result_sum = sum_ff;
      result_err = err_ff;
      if (go) begin
         unique case (tok.kind)
            aspe_pkg::KIND_OPEN: begin
               sum_in = '0;
               if (sp_ff < SPW'(STACK_DEPTH)) begin
                  wr_en  = 1'b1;
                  tos_in = wr_data;
                  sp_in  = sp_ff + 1'b1;
               end else begin
                  err_in = 1'b1;
               end
            end
            aspe_pkg::KIND_CLOSE: begin
               if (sp_ff != '0) begin
                  sum_in = sum_close;
                  tos_in = below_ff;
                  sp_in  = sp_ff - 1'b1;
               end else begin
                  sum_in = sum_commit;
                  err_in = 1'b1;
               end
            end
            default: begin
               sum_in = sum_commit;
            end
         endcase
         result_sum = sum_in;
         result_err = err_in;
         if (tok.last) begin
            sum_in = '0;
            sp_in  = '0;
            err_in = 1'b0;
         end
      end
      rd_full = sp_in - SPW'(2);
      rd_addr = rd_full[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         sp_ff  <= '0;
         err_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         sp_ff  <= sp_in;
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      below_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go && tok.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go && tok.last) begin
         rsp_value_ff <= result_sum;
         rsp_error_ff <= result_err;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_error = rsp_error_ff;

   `ASPE_ASSERT_NEXT(a_last_clears, clock, reset, go && tok.last, sp_ff == '0 && !err_ff && sum_ff == '0)
   `ASPE_ASSERT_NEXT(a_pop_depth, clock, reset, go && !tok.last && tok.kind == aspe_pkg::KIND_CLOSE && sp_ff != '0, sp_ff == $past(sp_ff) - 1'b1)
   `ASPE_ASSERT_IMPLIES(a_sp_bound, clock, reset, 1'b1, sp_ff <= SPW'(STACK_DEPTH))

endmodule

/* rtl/add_sub_paren_expression_evaluator.sv */
// ----------------------------------------------------------------------------
// Add/subtract expression evaluator with parentheses
// Evaluates one character per request and returns one result per expression.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle, back to back, as long as
// the result side keeps up. Digits are folded into a number in the front
// end; every other character becomes a token that passes through a
// two-entry queue into the back end, which updates the running sum and the
// parenthesis stack for each token. The stack is a memory of STACK_DEPTH
// entries with a registered top entry and a prefetched second entry, so
// consecutive closing parentheses also run at one per cycle unless a result
// is held. The result is registered in the back end when it takes the
// token of the last character. While a finished result waits, requests
// keep flowing until the last character of the next expression reaches
// the back end; the queue then fills and requests stall.
module add_sub_paren_expression_evaluator #(
   parameter int unsigned STACK_DEPTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [aspe_pkg::CHAR_W-1:0]         req_char_code,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [aspe_pkg::DATA_W-1:0]  rsp_value,
   output logic                                rsp_error
);

   logic                  q_full;
   logic                  q_push;
   logic                  q_pop;
   logic                  q_not_empty;
   aspe_pkg::token_type   q_token;
   aspe_pkg::token_type   q_head;

   aspe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last      (req_last),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_token       (q_token)
   );

   aspe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (q_token),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   aspe_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (q_not_empty),
      .tok       (q_head),
      .tok_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_value (rsp_value),
      .rsp_error (rsp_error)
   );

endmodule

/* verif/tb_add_sub_paren_expression_evaluator.sv */
// ----------------------------------------------------------------------------
// Testbench for the add/subtract expression evaluator with parentheses
// Streams expression characters into the block and checks every result
// against a predictor that evaluates the same stream. The run covers short
// directed expressions, random well-formed, deeply nested and malformed
// expressions, random idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import aspe_pkg::*;

class expr_scoreboard;

   typedef struct {
      logic [DATA_W-1:0] value;
      logic              error;
   } result_type;

   localparam int unsigned NEST_LIMIT = 32;

   logic [DATA_W-1:0] sum;
   logic              neg;
   logic [DATA_W-1:0] num;
   int unsigned       depth;
   logic              err;
   logic [DATA_W-1:0] saved_sum [NEST_LIMIT];
   logic              saved_neg [NEST_LIMIT];
   result_type        expected_results [$];
   int                failures;

   function new();
      failures = 0;
      clear();
   endfunction

   function void clear();
      sum   = '0;
      neg   = 1'b0;
      num   = '0;
      depth = 0;
      err   = 1'b0;
   endfunction

   function logic [DATA_W-1:0] with_sign(logic [DATA_W-1:0] v, logic n);
      return n ? (32'd0 - v) : v;
   endfunction

   function void note_request(logic [CHAR_W-1:0] c, logic l);
      result_type r;
      if (c >= CHAR_ZERO) begin
         num = num * 32'd10 + 32'(c - CHAR_ZERO);
      end else begin
         sum = sum + with_sign(num, neg);
         num = '0;
         case (c)
            CHAR_PLUS: begin
               neg = 1'b0;
            end
            CHAR_MINUS: begin
               neg = 1'b1;
            end
            CHAR_OPEN: begin
               if (depth < NEST_LIMIT) begin
                  saved_sum[depth] = sum;
                  saved_neg[depth] = neg;
                  depth++;
               end else begin
                  err = 1'b1;
               end
               sum = '0;
               neg = 1'b0;
            end
            CHAR_CLOSE: begin
               if (depth > 0) begin
                  depth--;
                  sum = with_sign(sum, saved_neg[depth]) + saved_sum[depth];
               end else begin
                  err = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      if (l) begin
         sum     = sum + with_sign(num, neg);
         r.value = sum;
         r.error = err;
         expected_results.push_back(r);
         clear();
      end
   endfunction

   function void check_result(logic [DATA_W-1:0] value, logic error);
      result_type r;
      if (expected_results.size() == 0) begin
         $error("result with no request pending: value %0d error %0b", $signed(value), error);
         failures++;
         return;
      end
      r = expected_results.pop_front();
      if (value !== r.value) begin
         $error("value: expected %0d, actual %0d", $signed(r.value), $signed(value));
         failures++;
      end
      if (error !== r.error) begin
         $error("error: expected %0b, actual %0b", r.error, error);
         failures++;
      end
   endfunction

endclass

module tb_add_sub_paren_expression_evaluator;

   localparam int unsigned      NEST_LIMIT = 32;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TOP   = 8'hFF;

   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       req_valid     = 1'b0;
   logic                       req_stall;
   logic [CHAR_W-1:0]          req_char_code = '0;
   logic                       req_last      = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall     = 1'b0;
   logic signed [DATA_W-1:0]   rsp_value;
   logic                       rsp_error;

   logic                       hold_off      = 1'b0;
   int                         send_idle_pct = 0;
   int                         recv_idle_pct = 0;
   int                         chars_sent    = 0;
   logic [CHAR_W-1:0]          expr_chars [$];
   expr_scoreboard             sb;

   add_sub_paren_expression_evaluator #(
      .STACK_DEPTH(NEST_LIMIT)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_code(req_char_code),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_value(rsp_value),
      .rsp_error(rsp_error)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_value, rsp_error);
      end
      rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
   end

   task automatic send_char(input logic [CHAR_W-1:0] c, input logic l);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      req_last      <= l;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sb.note_request(c, l);
      chars_sent++;
   endtask

   task automatic send_expr();
      for (int i = 0; i < expr_chars.size(); i++) begin
         send_char(expr_chars[i], i == expr_chars.size() - 1);
      end
      expr_chars.delete();
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         expr_chars.push_back(s[i]);
      end
      send_expr();
   endtask

   task automatic add_space();
      if ($urandom_range(7) == 0) begin
         expr_chars.push_back(CHAR_SPACE);
      end
   endtask

   task automatic add_number();
      int len;
      len = ($urandom_range(9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 3);
      repeat (len) begin
         if ($urandom_range(19) == 0) begin
            expr_chars.push_back(8'($urandom_range(8'h3A, 8'hFF)));
         end else begin
            expr_chars.push_back(8'($urandom_range(8'h30, 8'h39)));
         end
      end
   endtask

   task automatic add_operator();
      expr_chars.push_back($urandom_range(1) ? CHAR_PLUS : CHAR_MINUS);
   endtask

   task automatic build_balanced_expr();
      int terms;
      int opened;
      int closes;
      terms  = $urandom_range(1, 5);
      opened = 0;
      if ($urandom_range(3) == 0) begin
         expr_chars.push_back(CHAR_MINUS);
      end
      for (int t = 0; t < terms; t++) begin
         repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(3) == 0) begin
               expr_chars.push_back(CHAR_MINUS);
            end
            expr_chars.push_back(CHAR_OPEN);
            add_space();
            opened++;
         end
         add_number();
         add_space();
         if (opened > 0 && $urandom_range(1)) begin
            closes = $urandom_range(1, opened);
            repeat (closes) expr_chars.push_back(CHAR_CLOSE);
            opened -= closes;
         end
         if (t < terms - 1) begin
            add_operator();
            add_space();
         end
      end
      if ($urandom_range(9) != 0) begin
         repeat (opened) expr_chars.push_back(CHAR_CLOSE);
      end
   endtask

   task automatic build_deep_expr();
      int levels;
      levels = $urandom_range(28, 40);
      repeat (levels) begin
         if ($urandom_range(3) == 0) begin
            add_number();
            add_operator();
         end
         expr_chars.push_back(CHAR_OPEN);
      end
      add_number();
      repeat (levels) begin
         expr_chars.push_back(CHAR_CLOSE);
         if ($urandom_range(3) == 0) begin
            add_operator();
            add_number();
         end
      end
      repeat ($urandom_range(0, 2)) expr_chars.push_back(CHAR_CLOSE);
   endtask

   task automatic build_noise_expr();
      repeat ($urandom_range(1, 12)) begin
         case ($urandom_range(5))
            0: expr_chars.push_back(CHAR_OPEN);
            1: expr_chars.push_back(CHAR_CLOSE);
            2: add_operator();
            default: expr_chars.push_back(8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   task automatic build_random_expr();
      int pick;
      pick = $urandom_range(99);
      if (pick < 75) begin
         build_balanced_expr();
      end else if (pick < 83) begin
         build_deep_expr();
      end else begin
         build_noise_expr();
      end
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int target);
      int first;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      first         = chars_sent;
      while (chars_sent - first < target) begin
         build_random_expr();
         send_expr();
      end
   endtask

   initial begin
      #2_000_000;
      $display("tb_add_sub_paren_expression_evaluator: FAIL");
      $finish;
   end

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_text("0");
      expr_chars.push_back(CHAR_TOP);
      send_expr();
      send_text("12-(3+4)");
      send_text(")5");
      send_text("-(2");
      expr_chars.push_back(CHAR_NUL);
      expr_chars.push_back(CHAR_SLASH);
      send_expr();
      send_text("9");
      send_text("4+");
      send_text("3+(");

      run_phase(9, 78, 170);
      run_phase(78, 9, 170);

      // The receiver holds off while expressions keep arriving, so the
      // block backs up and has to stall its requests.
      fork
         begin
            hold_off <= 1'b1;
            repeat (400) @(posedge clock);
            hold_off <= 1'b0;
         end
      join_none
      run_phase(0, 0, 170);

      req_valid <= 1'b0;
      while (sb.expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      if (sb.failures == 0) begin
         $display("tb_add_sub_paren_expression_evaluator: PASS");
      end else begin
         $display("tb_add_sub_paren_expression_evaluator: FAIL");
      end
      $finish;
   end

endmodule
